// ----- design/tfpd_pkg.sv -----
package tfpd_pkg;

  localparam int SIDE     = 32;
  localparam int PIXELS   = SIDE * SIDE;
  localparam int PEC_POS  = (PIXELS + 1) * 2;
  localparam int IDLE_POS = PEC_POS + 1;
  localparam int POS_W    = $clog2(IDLE_POS + 1);
  localparam int RC_W     = $clog2(SIDE);
  localparam int PIX_W    = 2 * RC_W;

  localparam logic [7:0] CRC_POLY = 8'h07;

  localparam logic [15:0] HOT_THRESHOLD_RST   = 16'd250;
  localparam logic [10:0] MIN_HOT_PIXELS_RST  = 11'd20;
  localparam logic [7:0]  PASSERBY_FRAMES_RST = 8'd4;
  localparam logic [6:0]  DEVICE_ADDRESS_RST  = 7'h0A;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOT_PIXELS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASSERBY_FRAMES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Command kinds passed from the parser to the execution side
  localparam logic [2:0] K_FIRST   = 3'd0;
  localparam logic [2:0] K_LOW     = 3'd1;
  localparam logic [2:0] K_AMB     = 3'd2;
  localparam logic [2:0] K_PIX_OUT = 3'd3;
  localparam logic [2:0] K_PIX_IN  = 3'd4;
  localparam logic [2:0] K_PEC     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [15:0] ambient_temp;
    logic        pec_ok;
    logic        human_in_frame;
    logic [10:0] hot_pixel_count;
    logic        passenger_event;
  } out_t;

  typedef struct packed {
    logic [15:0] hot_threshold;
    logic [10:0] min_hot_pixels;
    logic [7:0]  passerby_frames;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] x);
    logic [7:0] c;
    c = x;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic in_region(input logic [RC_W-1:0] row, input logic [RC_W-1:0] col);
    logic r;
    r = 1'b0;
    if (row >= 5'd4 && row <= 5'd21) begin
      r = (col >= 5'd10 && col <= 5'd21);
    end else if (row >= 5'd22 && row <= 5'd26) begin
      r = (col >= 5'd9 && col <= 5'd22);
    end else if (row >= 5'd27) begin
      r = (col >= 5'd8 && col <= 5'd23);
    end
    return r;
  endfunction

endpackage

// ----- design/tfpd_front.sv -----
module tfpd_front import tfpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic full,
  output logic push,
  output cmd_t cmd
);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pix_off;
  logic [PIX_W-1:0] pix_idx;
  logic             accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  // a start mark restarts parsing at byte 0
  assign pos      = in_data.frame_start ? '0 : byte_position;
  assign pix_off  = pos - POS_W'(3);
  assign pix_idx  = pix_off[PIX_W:1];
  assign push     = accept && (pos != POS_W'(IDLE_POS));

  always_comb begin
    cmd.data = in_data.data_byte;
    if (pos == POS_W'(PEC_POS)) begin
      cmd.kind = K_PEC;
    end else if (pos == '0) begin
      cmd.kind = K_FIRST;
    end else if (!pos[0]) begin
      cmd.kind = K_LOW;
    end else if (pos == POS_W'(1)) begin
      cmd.kind = K_AMB;
    end else if (in_region(pix_idx[PIX_W-1:RC_W], pix_idx[RC_W-1:0])) begin
      cmd.kind = K_PIX_IN;
    end else begin
      cmd.kind = K_PIX_OUT;
    end
  end

  assign byte_position_next = (pos == POS_W'(IDLE_POS)) ? pos : pos + POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(IDLE_POS))
    else $error("byte position beyond idle");

endmodule

// ----- design/tfpd_queue.sv -----
module tfpd_queue import tfpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

// ----- design/tfpd_back.sv -----
module tfpd_back import tfpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [7:0]  running_crc;
  logic [7:0]  low_byte_latch;
  logic [15:0] ambient_word;
  logic [10:0] hot_count;
  logic [8:0]  detect_run;

  logic [7:0]  crc_base;
  logic [7:0]  crc_next;
  logic [15:0] word;
  logic        is_pec;
  logic        human;
  logic        passenger;
  logic [8:0]  run_step;
  logic        hot_hit;

  assign is_pec   = (q_cmd.kind == K_PEC);
  // results only wait on the output register; other beats flow past it
  assign pop      = q_valid && (!is_pec || !out_valid || out_ready);
  assign crc_base = (q_cmd.kind == K_FIRST) ? crc_byte({cfg.device_address, 1'b1})
                                            : running_crc;
  assign crc_next = crc_byte(q_cmd.data ^ crc_base);
  assign word     = {q_cmd.data, low_byte_latch};
  assign hot_hit  = (q_cmd.kind == K_PIX_IN) && (word >= cfg.hot_threshold) &&
                    (hot_count < cfg.min_hot_pixels);
  assign human    = (hot_count >= cfg.min_hot_pixels);
  assign run_step = human ? detect_run + 9'd1 : 9'd0;
  assign passenger = (run_step > {1'b0, cfg.passerby_frames});

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= '0;
      low_byte_latch <= '0;
      ambient_word   <= '0;
      hot_count      <= '0;
      detect_run     <= '0;
    end else if (pop) begin
      case (q_cmd.kind)
        K_FIRST: begin
          running_crc    <= crc_next;
          low_byte_latch <= q_cmd.data;
          hot_count      <= '0;
        end
        K_LOW: begin
          running_crc    <= crc_next;
          low_byte_latch <= q_cmd.data;
        end
        K_AMB: begin
          running_crc  <= crc_next;
          ambient_word <= word;
        end
        K_PIX_OUT, K_PIX_IN: begin
          running_crc <= crc_next;
          if (hot_hit) begin
            hot_count <= hot_count + 11'd1;
          end
        end
        K_PEC: begin
          detect_run <= passenger ? 9'd0 : run_step;
        end
        default: begin
          running_crc <= running_crc;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_pec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_pec) begin
      out_data.ambient_temp    <= ambient_word;
      out_data.pec_ok          <= (running_crc == q_cmd.data);
      out_data.human_in_frame  <= human;
      out_data.hot_pixel_count <= hot_count;
      out_data.passenger_event <= passenger;
    end
  end

  a_passenger_needs_human: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.passenger_event || out_data.human_in_frame))
    else $error("passenger flagged on a non-detecting frame");
  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (pop && is_pec && passenger) |=> (detect_run == 9'd0))
    else $error("detect run not cleared after passenger");

endmodule

// ----- design/thermal_frame_presence_detector_unit.sv -----
// Channel | Direction | Handshake              | Beat
// in      | input     | in_valid / in_ready    | in_t: one raw frame byte and start mark
// out     | output    | out_valid / out_ready  | out_t: one frame summary at the PEC byte
// cfg     | input     | cfg_we (no back-pressure) | cfg_index selects, cfg_data carries value
//
// One byte beat is taken every cycle while the four-entry command queue has room.
// A summary is registered when its PEC beat is popped from the queue head, once the beats ahead
// of it have drained from the queue; it stays valid until out_ready takes it.
// Reset (synchronous, rst high) clears the byte position, CRC, counters and queue, and
// loads the register defaults. A stalled output holds only a PEC beat at the queue head;
// beats behind it wait there, so input stalls once the queue fills.
module thermal_frame_presence_detector_unit import tfpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t cfg;
  logic push;
  logic full;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // Configuration registers: write only while the block is quiet
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hot_threshold   <= HOT_THRESHOLD_RST;
      cfg.min_hot_pixels  <= MIN_HOT_PIXELS_RST;
      cfg.passerby_frames <= PASSERBY_FRAMES_RST;
      cfg.device_address  <= DEVICE_ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOT_THRESHOLD:   cfg.hot_threshold   <= cfg_data;
        CFG_MIN_HOT_PIXELS:  cfg.min_hot_pixels  <= cfg_data[10:0];
        CFG_PASSERBY_FRAMES: cfg.passerby_frames <= cfg_data[7:0];
        CFG_DEVICE_ADDRESS:  cfg.device_address  <= cfg_data[6:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Front: track the byte position and classify each beat; drop bytes after the PEC
  tfpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Hold classified beats so either side can stall on its own
  tfpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Back: advance the CRC, assemble words, count hot pixels, emit the summary
  tfpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
